### design/otx_pkg.sv
// Package: shared types, constants and AES helper functions for the pad expander.
package otx_pkg;

  localparam int MaxLogChoices = 6;
  localparam int SlotW = 3;
  localparam int IdxW = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_INIT,
    ST_ROUND,
    ST_ACC,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       store;
    logic       key_load;
    logic       aes_init;
    logic       aes_round;
    logic       acc_clear;
    logic       acc_add;
    logic       out_load;
    logic [2:0] pair_sel;
    logic       key_sel;
  } otx_cmd_t;

  // S-box as a constant function table.
  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

### design/ot_one_of_n_pad_expander_top.sv
// Top level: 1-of-N pad expander from 1-of-2 key pairs using AES-128.
// A non-closing beat is stored and the block stays ready. A closing beat starts pad output:
// for each pad, every key pair goes through load, whitening, ten rounds and XOR in
// the single iterative AES round unit, then the pad is emitted; an emit waits while
// a held pad is not yet taken by out_ready.
// Output is registered; in_ready is low while a group is emitted.
// Synchronous active-low reset clears the pair count and sets log_choices to one.
module ot_one_of_n_pad_expander_top import otx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_key_zero_low,
  input  logic [63:0] in_key_zero_high,
  input  logic [63:0] in_key_one_low,
  input  logic [63:0] in_key_one_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_pad_low,
  output logic [63:0] out_pad_high,
  output logic [5:0]  out_choice_index,
  output logic        out_group_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  otx_cmd_t        cmd;
  logic [IdxW-1:0] idx;
  logic            last;

  otx_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .cfg_wdata, .cfg_we, .cmd, .idx, .last
  );

  otx_dp u_dp (
    .clk, .cmd, .idx, .last,
    .in_key_zero_low, .in_key_zero_high, .in_key_one_low, .in_key_one_high,
    .out_pad_low, .out_pad_high, .out_choice_index, .out_group_last
  );

endmodule

### design/otx_ctrl.sv
// Controller: sequences key loading, AES rounds and pad emission.
module otx_ctrl import otx_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  logic [2:0]     cfg_wdata,
  input  logic           cfg_we,
  output otx_cmd_t       cmd,
  output logic [IdxW-1:0] idx,
  output logic           last
);

  state_t         state_r, state_nxt;
  logic [2:0]     log_r;
  logic [2:0]     loaded_r, loaded_nxt;
  logic [2:0]     power;
  logic [2:0]     pair_r, pair_nxt;
  logic [3:0]     rnd_r, rnd_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [IdxW-1:0] top_idx;
  logic [IdxW-1:0] idx_step;
  logic           ov_r, ov_nxt;
  logic           closes;
  logic [2:0]     slot;

  // Clamp the group size to the legal range.
  always_comb begin
    if (log_r == 3'd0) power = 3'd1;
    else if (log_r > 3'(MaxLogChoices)) power = 3'(MaxLogChoices);
    else power = log_r;
  end

  assign slot     = (loaded_r >= 3'(MaxLogChoices)) ? 3'(MaxLogChoices - 1) : loaded_r;
  assign closes   = (slot + 3'd1) >= power;
  assign top_idx  = IdxW'((7'd1 << power) - 7'd1);
  assign idx_step = idx_r + IdxW'(1);
  assign idx      = idx_r;
  assign last     = (idx_r == top_idx);
  assign out_valid = ov_r;

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      log_r    <= 3'd1;
      loaded_r <= '0;
      pair_r   <= '0;
      rnd_r    <= '0;
      idx_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
      pair_r   <= pair_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        log_r <= cfg_wdata;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt  = state_r;
    loaded_nxt = loaded_r;
    pair_nxt   = pair_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    ov_nxt     = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (closes) begin
            loaded_nxt = '0;
            idx_nxt    = '0;
            pair_nxt   = '0;
            state_nxt  = ST_LOAD;
          end else begin
            loaded_nxt = slot + 3'd1;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        rnd_nxt   = 4'd1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (rnd_r == 4'd10) begin
          state_nxt = ST_ACC;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      ST_ACC: begin
        if (pair_r + 3'd1 >= power) begin
          state_nxt = ST_EMIT;
        end else begin
          pair_nxt  = pair_r + 3'd1;
          state_nxt = ST_LOAD;
        end
      end
      ST_EMIT: begin
        // The index steps once its pad is staged, except after the last pad.
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          pair_nxt = '0;
          if (last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_step;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    cmd.pair_sel = pair_r;
    cmd.key_sel  = idx_r[pair_r];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.store = in_valid;
        cmd.pair_sel = slot;
      end
      ST_LOAD:  begin
        cmd.key_load = 1'b1;
        if (pair_r == 3'd0) cmd.acc_clear = 1'b1;
      end
      ST_INIT:  cmd.aes_init = 1'b1;
      ST_ROUND: cmd.aes_round = 1'b1;
      ST_ACC:   cmd.acc_add = 1'b1;
      ST_EMIT:  cmd.out_load = !ov_r || out_ready;
      default: cmd = '0;
    endcase
  end

endmodule

### design/otx_dp.sv
// Datapath: key store, AES round unit with key schedule, XOR accumulator, output register.
module otx_dp import otx_pkg::*; (
  input  logic           clk,
  input  otx_cmd_t       cmd,
  input  logic [IdxW-1:0] idx,
  input  logic           last,
  input  logic [63:0]    in_key_zero_low,
  input  logic [63:0]    in_key_zero_high,
  input  logic [63:0]    in_key_one_low,
  input  logic [63:0]    in_key_one_high,
  output logic [63:0]    out_pad_low,
  output logic [63:0]    out_pad_high,
  output logic [IdxW-1:0] out_choice_index,
  output logic           out_group_last
);

  logic [255:0] store_r [MaxLogChoices];
  logic [127:0] key_r, st_r, acc_r;
  logic [7:0]   rc_r;
  logic [127:0] rk_nxt, st_nxt, sb, mc;
  logic [63:0]  pl_r, ph_r;
  logic [IdxW-1:0] ci_r;
  logic         gl_r;
  logic [255:0] sel_pair;
  logic [31:0]  tw;

  assign sel_pair = store_r[cmd.pair_sel];

  // Key schedule step.
  always_comb begin
    tw = {sbox(key_r[103:96]), sbox(key_r[127:120]), sbox(key_r[119:112]),
          sbox(key_r[111:104]) ^ rc_r};
    rk_nxt[31:0]   = key_r[31:0] ^ tw;
    rk_nxt[63:32]  = key_r[63:32] ^ rk_nxt[31:0];
    rk_nxt[95:64]  = key_r[95:64] ^ rk_nxt[63:32];
    rk_nxt[127:96] = key_r[127:96] ^ rk_nxt[95:64];
  end

  // SubBytes plus ShiftRows, then MixColumns (skipped in the last round), then AddRoundKey.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        sb[8*(k+4*c) +: 8] = sbox(st_r[8*(k + 4*((c+k)%4)) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sb[32*c +: 8]; a1 = sb[32*c+8 +: 8];
      a2 = sb[32*c+16 +: 8]; a3 = sb[32*c+24 +: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[32*c +: 8]    = a0 ^ al ^ xt(a0 ^ a1);
      mc[32*c+8 +: 8]  = a1 ^ al ^ xt(a1 ^ a2);
      mc[32*c+16 +: 8] = a2 ^ al ^ xt(a2 ^ a3);
      mc[32*c+24 +: 8] = a3 ^ al ^ xt(a3 ^ a0);
    end
    st_nxt = ((rc_r == 8'h36) ? sb : mc) ^ rk_nxt;
  end

  // Storage and round registers.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      store_r[cmd.pair_sel] <= {in_key_one_high, in_key_one_low,
                                in_key_zero_high, in_key_zero_low};
    end
    if (cmd.key_load) begin
      key_r <= cmd.key_sel ? sel_pair[255:128] : sel_pair[127:0];
      rc_r  <= 8'h01;
    end
    if (cmd.acc_clear) acc_r <= '0;
    if (cmd.aes_init) st_r <= {64'd0, 58'd0, idx} ^ key_r;
    if (cmd.aes_round) begin
      st_r  <= st_nxt;
      key_r <= rk_nxt;
      rc_r  <= xt(rc_r);
    end
    if (cmd.acc_add) acc_r <= acc_r ^ st_r;
    if (cmd.out_load) begin
      pl_r <= acc_r[63:0];
      ph_r <= acc_r[127:64];
      ci_r <= idx;
      gl_r <= last;
    end
  end

  assign out_pad_low      = pl_r;
  assign out_pad_high     = ph_r;
  assign out_choice_index = ci_r;
  assign out_group_last   = gl_r;

endmodule

### design/otx_checker.sv
// Checker: port-level properties of the pad expander, bound to the top level.
module otx_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_choice_index,
  input logic       out_group_last
);

  // A held result beat keeps its index.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_choice_index))
    else $error("index changed under stall");

  // No input is taken while pads of a group are still being produced.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_group_last |-> !in_ready)
    else $error("input accepted mid-group");

  // A group's last beat never has index zero.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_group_last |-> out_choice_index != 6'd0)
    else $error("group_last on index zero");

endmodule

bind ot_one_of_n_pad_expander_top otx_checker u_chk (.*);

### verif/tb_ot_one_of_n_pad_expander_top.sv
// Testbench for the one-of-N pad expander: random key pairs, AES-based pad prediction.
`timescale 1ns / 1ps

module tb_ot_one_of_n_pad_expander_top;
  import otx_pkg::*;

  typedef struct {
    logic [63:0] k0_lo, k0_hi, k1_lo, k1_hi;
  } key_pair_t;

  typedef struct {
    logic [63:0] pad_lo, pad_hi;
    logic [5:0]  index;
    logic        last;
  } pad_beat_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [63:0] in_key_zero_low, in_key_zero_high, in_key_one_low, in_key_one_high;
  logic        out_valid, out_ready;
  logic [63:0] out_pad_low, out_pad_high;
  logic [5:0]  out_choice_index;
  logic        out_group_last;
  logic        cfg_we;
  logic [2:0]  cfg_wdata;

  ot_one_of_n_pad_expander_top dut (.*);

  key_pair_t pending_pairs[$];
  pad_beat_t expected_pads[$];
  key_pair_t group_keys[MaxLogChoices];
  int          pairs_held;
  logic [2:0]  log_choices_shadow;
  int          error_count;
  int          burst_left, gap_left;
  int          stall_phase;
  logic [7:0]  sbox_table[256];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] mul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Encrypt one 128-bit block (little-endian bytes) under a 128-bit key.
  function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] blk);
    logic [7:0] rk[176];
    logic [7:0] s[16], t[16], w[4], tmp, a0, a1, a2, a3, all;
    logic [7:0] rc;
    logic [127:0] res;
    rc = 8'h01;
    for (int k = 0; k < 16; k++) rk[k] = key[8*k +: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int k = 0; k < 4; k++) w[k] = rk[i-4+k];
      if (i % 16 == 0) begin
        tmp = w[0];
        w[0] = sbox_table[w[1]] ^ rc;
        w[1] = sbox_table[w[2]];
        w[2] = sbox_table[w[3]];
        w[3] = sbox_table[tmp];
        rc = mul2(rc);
      end
      for (int k = 0; k < 4; k++) rk[i+k] = rk[i-16+k] ^ w[k];
    end
    for (int k = 0; k < 16; k++) s[k] = blk[8*k +: 8] ^ rk[k];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int k = 0; k < 4; k++) t[k+4*c] = sbox_table[s[k + 4*((c+k)%4)]];
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ all ^ mul2(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ mul2(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ mul2(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ mul2(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) s[k] = t[k] ^ rk[16*r+k];
    end
    for (int k = 0; k < 16; k++) res[8*k +: 8] = s[k];
    return res;
  endfunction

  // Store an accepted pair and, when the group closes, queue all its pads.
  task automatic absorb_pair(input key_pair_t kp);
    int power, slot, n;
    logic [127:0] acc, key;
    pad_beat_t pb;
    power = (log_choices_shadow < 1) ? 1 :
            (log_choices_shadow > MaxLogChoices) ? MaxLogChoices : log_choices_shadow;
    slot = (pairs_held >= MaxLogChoices) ? MaxLogChoices - 1 : pairs_held;
    group_keys[slot] = kp;
    pairs_held = (slot + 1) & 7;
    if (pairs_held < power) return;
    pairs_held = 0;
    n = 1 << power;
    for (int i = 0; i < n; i++) begin
      acc = '0;
      for (int j = 0; j < power; j++) begin
        key = ((i >> j) & 1) ? {group_keys[j].k1_hi, group_keys[j].k1_lo}
                             : {group_keys[j].k0_hi, group_keys[j].k0_lo};
        acc ^= aes128(key, {64'd0, 64'(i)});
      end
      pb.pad_lo = acc[63:0];
      pb.pad_hi = acc[127:64];
      pb.index = 6'(i);
      pb.last = (i == n - 1);
      expected_pads = {expected_pads, pb};
    end
  endtask

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) absorb_pair('{in_key_zero_low, in_key_zero_high,
                                  in_key_one_low, in_key_one_high});
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_valid <= 1'b1;
        in_key_zero_low  <= pending_pairs[0].k0_lo;
        in_key_zero_high <= pending_pairs[0].k0_hi;
        in_key_one_low   <= pending_pairs[0].k1_lo;
        in_key_one_high  <= pending_pairs[0].k1_hi;
        void'(pending_pairs.pop_front());
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 6);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted pad beat with the oldest expected one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= (stall_phase + 1) % 23;
      out_ready <= (stall_phase < 8) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_valid && out_ready) begin
        if (expected_pads.size() == 0) begin
          $display("%0t: unexpected pad beat index %0d", $time, out_choice_index);
          error_count++;
        end else begin
          if (out_pad_low !== expected_pads[0].pad_lo) begin
            $display("%0t: pad_low exp %h act %h", $time, expected_pads[0].pad_lo, out_pad_low);
            error_count++;
          end
          if (out_pad_high !== expected_pads[0].pad_hi) begin
            $display("%0t: pad_high exp %h act %h", $time, expected_pads[0].pad_hi,
                     out_pad_high);
            error_count++;
          end
          if (out_choice_index !== expected_pads[0].index) begin
            $display("%0t: choice_index exp %0d act %0d", $time, expected_pads[0].index,
                     out_choice_index);
            error_count++;
          end
          if (out_group_last !== expected_pads[0].last) begin
            $display("%0t: group_last exp %b act %b", $time, expected_pads[0].last,
                     out_group_last);
            error_count++;
          end
          void'(expected_pads.pop_front());
        end
      end
    end
  end

  function automatic key_pair_t random_pair();
    key_pair_t kp;
    kp.k0_lo = {$urandom, $urandom};
    kp.k0_hi = {$urandom, $urandom};
    kp.k1_lo = {$urandom, $urandom};
    kp.k1_hi = {$urandom, $urandom};
    return kp;
  endfunction

  // Queue one pair for the driver.
  task automatic add_pair(input key_pair_t kp);
    pending_pairs = {pending_pairs, kp};
  endtask

  // Wait until the block has drained, then write the group size.
  task automatic set_log_choices(input logic [2:0] value);
    while (pending_pairs.size() > 0 || in_valid || expected_pads.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    log_choices_shadow = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus: directed extremes and odd settings, then random groups.
  initial begin
    logic [2:0] sizes[8];
    sizes = '{3'd1, 3'd2, 3'd0, 3'd3, 3'd7, 3'd1, 3'd2, 3'd4};
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_key_zero_low = '0; in_key_zero_high = '0;
    in_key_one_low = '0; in_key_one_high = '0;
    pairs_held = 0;
    log_choices_shadow = 3'd1;
    error_count = 0;
    for (int i = 0; i < 256; i++) sbox_table[i] = sbox(8'(i));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset value of one: all-zero and all-one keys.
    add_pair('{'0, '0, '1, '1});
    add_pair('{'1, '1, '0, '0});
    set_log_choices(3'd0);
    add_pair(random_pair());
    set_log_choices(3'd6);
    for (int i = 0; i < 6; i++) add_pair(random_pair());
    set_log_choices(3'd7);
    for (int i = 0; i < 6; i++) add_pair(random_pair());
    // Change mid-group: load three pairs at size 6, then shrink to 2.
    for (int i = 0; i < 3; i++) add_pair(random_pair());
    set_log_choices(3'd2);
    add_pair(random_pair());
    set_log_choices(3'd3);
    add_pair(random_pair());
    add_pair(random_pair());
    add_pair(random_pair());

    // Random part, mostly small groups with an occasional large one.
    for (int phase = 0; phase < 13; phase++) begin
      set_log_choices((phase % 7 == 6) ? 3'd6 : sizes[$urandom_range(0, 7)]);
      for (int i = 0; i < 20; i++) add_pair(random_pair());
    end

    while (pending_pairs.size() > 0 || in_valid || expected_pads.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_pads.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #60ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### filelist.f
design/otx_pkg.sv
design/otx_ctrl.sv
design/otx_dp.sv
design/ot_one_of_n_pad_expander_top.sv
design/otx_checker.sv
verif/tb_ot_one_of_n_pad_expander_top.sv
